### design/mexp_pkg.sv
// Package for the modular exponentiation block: widths, register codes and
// the request/response types between the sequencer and the serial multiplier.
// No dependencies.
package mexp_pkg;

  // Operand width used by the arithmetic; port fields are DATA_W wide.
  localparam int WIDTH     = 32;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = $clog2(WIDTH);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPONENT = 1'b0,
    REG_MODULUS  = 1'b1
  } cfg_reg_t;

  // Start of one modular multiplication: mcand * mplier mod modulus.
  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] mcand;
    logic [WIDTH-1:0] mplier;
  } mm_req_t;

  // Completion of one modular multiplication.
  typedef struct packed {
    logic             done;
    logic [WIDTH-1:0] value;
  } mm_rsp_t;

endpackage

### design/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle,
// most significant bit first. Depends on mexp_pkg.
module mexp_mulmod (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mexp_pkg::mm_req_t       req,
  input  logic [mexp_pkg::WIDTH:0] modulus,
  output mexp_pkg::mm_rsp_t       rsp
);
  import mexp_pkg::*;

  logic             busy_r,   busy_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic [WIDTH-1:0] acc_r,    acc_nxt;
  logic [WIDTH-1:0] mcand_r,  mcand_nxt;
  logic [WIDTH-1:0] mplier_r, mplier_nxt;
  logic             done_r,   done_nxt;
  logic [WIDTH-1:0] value_r,  value_nxt;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] mod_x1;
  logic [WIDTH+1:0] mod_x2;
  logic [WIDTH+1:0] reduced;

  // One step: double the accumulator, add the multiplicand on a one bit,
  // then subtract the modulus once or twice to stay below it.
  always_comb begin
    mod_x1 = (WIDTH+2)'(modulus);
    mod_x2 = {modulus, 1'b0};
    sum    = {1'b0, acc_r, 1'b0} + (mplier_r[WIDTH-1] ? (WIDTH+2)'(mcand_r) : '0);
    if (sum >= mod_x2) begin
      reduced = sum - mod_x2;
    end else if (sum >= mod_x1) begin
      reduced = sum - mod_x1;
    end else begin
      reduced = sum;
    end
  end

  // Sequencing of the multiplier bits.
  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    done_nxt   = 1'b0;
    value_nxt  = value_r;
    if (busy_r) begin
      acc_nxt    = reduced[WIDTH-1:0];
      mplier_nxt = {mplier_r[WIDTH-2:0], 1'b0};
      cnt_nxt    = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WIDTH-1)) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        value_nxt = reduced[WIDTH-1:0];
      end
    end else if (req.start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      acc_nxt    = '0;
      mcand_nxt  = req.mcand;
      mplier_nxt = req.mplier;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    value_r  <= value_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = value_r;

endmodule

### design/modular_exponentiation.sv
// Top level of the modular exponentiation block: configuration registers,
// square-and-multiply sequencer and output register.
// Depends on mexp_pkg and mexp_mulmod.
//
// Usage: write the exponent (index 0) and modulus (index 1) through the
// cfg_ port while the block is idle; both reset to 1. A modulus of zero
// makes all arithmetic wrap at 2^WIDTH. Each word accepted on the in_
// channel yields one word on the out_ channel: base^exponent mod modulus,
// and 1 whenever the exponent is zero.
// The base is first reduced by one pass through the serial multiplier.
// Each exponent bit then costs a squaring (except the top one bit) and, for
// a one bit, a multiplication, each a further pass through the multiplier.
// The number of operations k is at most 2*WIDTH-1, and the single shared
// bit-serial multiplier performs them one after another.
// in_tready is high only while no item is in progress. A finished result
// sits in the output register; if the receiver stalls with an older result
// still unread, the block holds the new result and waits. Reset is
// synchronous and active low and clears all control state.
module modular_exponentiation (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mexp_pkg::DATA_W-1:0]     in_tdata,   // [31:0] base_value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mexp_pkg::DATA_W-1:0]     out_tdata,  // [31:0] power_result
  input  logic                            cfg_we,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mexp_pkg::DATA_W-1:0]     cfg_wdata
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_STEP,
    S_MUL,
    S_SQR,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [WIDTH-1:0] exp_cfg_r, exp_cfg_nxt;
  logic [WIDTH-1:0] mod_cfg_r, mod_cfg_nxt;
  logic [WIDTH-1:0] e_r, e_nxt;
  logic [WIDTH:0]   m_r, m_nxt;
  logic [WIDTH-1:0] r_r, r_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_data_r, out_data_nxt;

  mm_req_t req;
  mm_rsp_t rsp;

  // Configuration writes.
  always_comb begin
    exp_cfg_nxt = exp_cfg_r;
    mod_cfg_nxt = mod_cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_EXPONENT: exp_cfg_nxt = cfg_wdata[WIDTH-1:0];
        REG_MODULUS:  mod_cfg_nxt = cfg_wdata[WIDTH-1:0];
      endcase
    end
  end

  // Square-and-multiply sequencer, least significant exponent bit first.
  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    r_nxt         = r_r;
    b_nxt         = b_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    req.start     = 1'b0;
    req.mcand     = r_r;
    req.mplier    = b_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          // The base is reduced as 1 * base mod modulus.
          e_nxt      = exp_cfg_r;
          m_nxt      = (mod_cfg_r == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, mod_cfg_r};
          r_nxt      = WIDTH'(1);
          req.start  = 1'b1;
          req.mcand  = WIDTH'(1);
          req.mplier = in_tdata[WIDTH-1:0];
          state_nxt  = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (rsp.done) begin
          b_nxt     = rsp.value;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        priority if (e_r == '0) begin
          state_nxt = S_DONE;
        end else if (e_r[0]) begin
          req.start = 1'b1;
          state_nxt = S_MUL;
        end else begin
          req.mcand = b_r;
          req.start = 1'b1;
          state_nxt = S_SQR;
        end
      end
      S_MUL: begin
        if (rsp.done) begin
          r_nxt     = rsp.value;
          e_nxt     = {e_r[WIDTH-1:1], 1'b0};
          state_nxt = S_STEP;
        end
      end
      S_SQR: begin
        if (rsp.done) begin
          b_nxt     = rsp.value;
          e_nxt     = {1'b0, e_r[WIDTH-1:1]};
          state_nxt = S_STEP;
        end
      end
      S_DONE: begin
        // Load the output register once the previous word is gone.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = r_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_cfg_r   <= WIDTH'(1);
      mod_cfg_r   <= WIDTH'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_cfg_r   <= exp_cfg_nxt;
      mod_cfg_r   <= mod_cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    e_r        <= e_nxt;
    m_r        <= m_nxt;
    r_r        <= r_nxt;
    b_r        <= b_nxt;
    out_data_r <= out_data_nxt;
  end

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .modulus (m_r),
    .rsp     (rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_data_r);

endmodule

### tb/modular_exponentiation_tb.sv
// Self-checking testbench for modular_exponentiation: streams base words in,
// predicts each power word and checks the output stream under random stalls.
// Depends on mexp_pkg and the modular_exponentiation design files.
`timescale 1ns / 1ps

module modular_exponentiation_tb;

  import mexp_pkg::*;

  localparam int IDLE_PCT     = 32;
  localparam int HOLD_CYCLES  = 5000;
  localparam int HOLD_AFTER   = 60;
  localparam int QUIET_FROM   = 150;
  localparam int QUIET_TO     = 200;
  localparam int STALL_LIMIT  = 20000;
  localparam int RAND_PHASES  = 10;
  localparam int RAND_PER_SET = 29;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic              cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_EXPONENT;
  logic [DATA_W-1:0] cfg_wdata  = '0;

  // Base words waiting to be sent and power words waiting to come back.
  logic [DATA_W-1:0] base_queue[$];
  logic [DATA_W-1:0] power_queue[$];

  // Shadow copies of the configuration registers.
  logic [DATA_W-1:0] exp_shadow = 32'd1;
  logic [DATA_W-1:0] mod_shadow = 32'd1;

  int unsigned mismatches   = 0;
  int unsigned bases_sent   = 0;
  int unsigned powers_seen  = 0;
  int unsigned hold_cnt     = 0;
  logic        hold_done    = 1'b0;
  int unsigned stall_cycles = 0;

  modular_exponentiation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [31:0] base_value
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [31:0] power_result
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Reduce a product by the modulus; a zero modulus wraps at 2^WIDTH.
  function automatic logic [63:0] reduce_mod(input logic [63:0] x, input logic [63:0] m);
    if (m == 64'd0) return {32'd0, x[WIDTH-1:0]};
    return x % m;
  endfunction

  // Right-to-left square-and-multiply over the exponent bits.
  function automatic logic [DATA_W-1:0] predict_power(input logic [DATA_W-1:0] base,
                                                      input logic [DATA_W-1:0] e_reg,
                                                      input logic [DATA_W-1:0] m_reg);
    logic [63:0]       m;
    logic [63:0]       b;
    logic [63:0]       r;
    logic [WIDTH-1:0]  e;
    int                k;
    m = {32'd0, m_reg[WIDTH-1:0]};
    e = e_reg[WIDTH-1:0];
    b = reduce_mod({32'd0, base[WIDTH-1:0]}, m);
    r = 64'd1;
    for (k = 0; k < WIDTH && e != '0; k++) begin
      if (e[0]) r = reduce_mod(r * b, m);
      b = reduce_mod(b * b, m);
      e = e >> 1;
    end
    return r[DATA_W-1:0];
  endfunction

  task automatic report_mismatch(input logic [DATA_W-1:0] got, input logic [DATA_W-1:0] want,
                                 input logic unexpected);
    if (unexpected) begin
      $display("ERROR: power word %h arrived with nothing expected", got);
    end else begin
      $display("ERROR: power word %h, expected %h", got, want);
    end
    mismatches++;
  endtask

  // Driver: offers queued base words and records the expected power on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        power_queue.push_back(predict_power(in_tdata, exp_shadow, mod_shadow));
        bases_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (base_queue.size() != 0 &&
            ((bases_sent >= QUIET_FROM && bases_sent < QUIET_TO) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= base_queue.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each power word and throttles out_tready, with one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (power_queue.size() == 0) begin
          report_mismatch(out_tdata, '0, 1'b1);
        end else if (out_tdata !== power_queue[0]) begin
          report_mismatch(out_tdata, power_queue.pop_front(), 1'b0);
        end else begin
          void'(power_queue.pop_front());
        end
        powers_seen++;
      end
      if (hold_cnt != 0) begin
        out_tready <= 1'b0;
        hold_cnt   <= hold_cnt - 1;
      end else if (!hold_done && powers_seen >= HOLD_AFTER) begin
        hold_done  <= 1'b1;
        hold_cnt   <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (powers_seen >= QUIET_FROM && powers_seen < QUIET_TO) ||
                      ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Wait until every base word is sent and every power word has come back.
  task automatic drain();
    while (base_queue.size() != 0 || in_tvalid || power_queue.size() != 0) @(posedge clk);
  endtask

  // Write both registers once the block is idle.
  task automatic apply_setting(input logic [DATA_W-1:0] e, input logic [DATA_W-1:0] m);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_EXPONENT;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_idx   <= REG_MODULUS;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    exp_shadow = e;
    mod_shadow = m;
  endtask

  initial begin
    logic [DATA_W-1:0] e;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] b;
    int                p;
    int                i;
    int unsigned       pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: exponent one, modulus one.
    base_queue.push_back(32'h0000_0000);
    base_queue.push_back(32'h0000_0007);
    base_queue.push_back(32'hFFFF_FFFF);

    // Exponent zero yields one, even with a modulus of one.
    apply_setting(32'd0, 32'd1);
    base_queue.push_back(32'h0000_0000);
    base_queue.push_back(32'hFFFF_FFFF);
    apply_setting(32'd0, 32'hFFFF_FFFF);
    base_queue.push_back(32'h0000_0005);

    // Modulus one with a nonzero exponent yields zero.
    apply_setting(32'd5, 32'd1);
    base_queue.push_back(32'h0000_0009);

    // Largest exponent and modulus.
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    base_queue.push_back(32'hFFFF_FFFF);
    base_queue.push_back(32'hFFFF_FFFE);
    base_queue.push_back(32'h0000_0002);

    // Bases at and just above the modulus.
    apply_setting(32'd65537, 32'hFFFF_FFFB);
    base_queue.push_back(32'hFFFF_FFFB);
    base_queue.push_back(32'hFFFF_FFFC);
    base_queue.push_back(32'd123456789);

    // A zero modulus wraps every product at 2^WIDTH.
    apply_setting(32'd3, 32'd0);
    base_queue.push_back(32'hFFFF_FFFF);
    base_queue.push_back(32'h1234_5678);

    // Only the top exponent bit set.
    apply_setting(32'h8000_0000, 32'd1000003);
    base_queue.push_back(32'h0000_0002);
    base_queue.push_back(32'd1000002);

    apply_setting(32'd2, 32'd2);
    base_queue.push_back(32'h0000_0000);
    base_queue.push_back(32'h0000_0001);
    base_queue.push_back(32'h0000_0003);

    // Random settings, each followed by a burst of random bases.
    for (p = 0; p < RAND_PHASES; p++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)       e = $urandom();
      else if (pick < 8)  e = $urandom_range(1, 64);
      else if (pick < 9)  e = 32'd0;
      else                e = $urandom() | 32'hFFFF_0000;
      pick = $urandom_range(0, 19);
      if (pick < 8)       m = $urandom();
      else if (pick < 14) m = $urandom_range(1, 1000);
      else if (pick < 16) m = 32'hFFFF_FFFF;
      else if (pick < 18) m = 32'd1;
      else if (pick < 19) m = 32'd0;
      else                m = $urandom() | 32'h8000_0000;
      apply_setting(e, m);
      for (i = 0; i < RAND_PER_SET; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)      b = $urandom();
        else if (pick < 8) b = $urandom_range(0, 15);
        else               b = m + $urandom_range(0, 2) - 32'd1;
        base_queue.push_back(b);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
